[rtl/hac_pkg.sv]
package hac_pkg;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_SCAN  = 2'd2;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_REALLOC = 3'd1;
   localparam logic [2:0] STATUS_DOUBLE  = 3'd2;
   localparam logic [2:0] STATUS_BAD     = 3'd3;
   localparam logic [2:0] STATUS_LEAK    = 3'd4;
   localparam logic [2:0] STATUS_FULL    = 3'd5;

   localparam int MAX_RESULTS = 32;
   localparam int LEAK_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] OUT_EVENT     = 2'd0;
   localparam logic [1:0] OUT_LEAK_MID  = 2'd1;
   localparam logic [1:0] OUT_LEAK_LAST = 2'd2;
   localparam logic [1:0] OUT_SCAN_OK   = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [47:0] block_address;
      logic [31:0] block_bytes;
      logic [31:0] site_line;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] report_address;
      logic [31:0] report_bytes;
      logic [31:0] report_line;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] address;
      logic [31:0] bytes;
      logic [31:0] alloc_line;
      logic [31:0] free_line;
      logic        freed;
      logic        free_seen;
   } entry_type;

   typedef struct packed {
      logic       req_load;
      logic       rd_en;
      logic       wr_en;
      logic       pend_load;
      logic       out_load;
      logic [1:0] out_sel;
      logic       found;
      logic       full;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       hit;
      logic       live;
      logic       out_free;
   } stat_type;

endpackage

[rtl/heap_allocation_checker_unit.sv]
// Heap allocation checker.
// Request channel (req_valid / req_ready / req_payload): one event per request,
// func selects allocation, free or leak scan; func 3 is taken and dropped.
// Response channel (rsp_valid / rsp_ready / rsp_payload): one response per
// allocation or free, one per live block on a scan, at most MAX_RESULTS (last
// set on the final one), or a single ok response when nothing is live.
// The table is a single-port memory searched one entry per cycle in order,
// except while a scan is held for a waiting response. Allocation / free:
// at most TABLE_DEPTH entries are searched, and the search stops early on a
// match. A scan searches the entries in use, and rsp_ready can hold it.
// One request is in work at a time; req_ready is high only between requests,
// so the next request is taken only after the previous one is done.
// The response register lets the next request be taken while a result waits.
// When rsp_ready is low the block holds its search at the point where it
// needs to post a response, and resumes once the register frees up.
// Reset empties the table at once (the entry count clears); no clearing pass.
// A full table answers table full for an unknown address and inserts nothing.
module heap_allocation_checker_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hac_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hac_pkg::rsp_type rsp_payload
);
   import hac_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] mem_idx;

   hac_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd),
      .mem_idx  (mem_idx)
   );

   hac_dp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .mem_idx    (mem_idx),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

[rtl/hac_dp.sv]
module hac_dp #(
   parameter int TABLE_DEPTH = 32,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  hac_pkg::req_type req_payload,
   input  hac_pkg::cmd_type cmd,
   input  logic [IDX_W-1:0] mem_idx,
   output hac_pkg::stat_type stat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hac_pkg::rsp_type rsp_payload
);
   import hac_pkg::*;

   entry_type table_mem [TABLE_DEPTH];

   req_type   req_ff;
   entry_type rd_data_ff;
   entry_type pend_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   entry_type fresh;
   entry_type eff;
   entry_type entry_wr;
   rsp_type   event_rsp;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         table_mem[mem_idx] <= entry_wr;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= table_mem[mem_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_payload;
      end
      if (cmd.pend_load) begin
         pend_ff <= rd_data_ff;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      fresh            = '0;
      fresh.address    = req_ff.block_address;
      fresh.freed      = 1'b1;
      eff              = cmd.found ? rd_data_ff : fresh;
      entry_wr         = eff;
      event_rsp        = '0;
      event_rsp.report_address = req_ff.block_address;
      event_rsp.last   = 1'b1;
      event_rsp.status = STATUS_OK;
      if (cmd.full) begin
         event_rsp.status = STATUS_FULL;
      end else if (req_ff.func == FUNC_ALLOC) begin
         if (!eff.freed) begin
            event_rsp.status       = STATUS_REALLOC;
            event_rsp.report_bytes = eff.bytes;
            event_rsp.report_line  = eff.alloc_line;
         end else begin
            entry_wr.bytes      = req_ff.block_bytes;
            entry_wr.alloc_line = req_ff.site_line;
            entry_wr.freed      = 1'b0;
         end
      end else begin
         if (eff.freed) begin
            if (eff.free_seen) begin
               event_rsp.status      = STATUS_DOUBLE;
               event_rsp.report_line = eff.free_line;
            end else begin
               event_rsp.status = STATUS_BAD;
            end
         end else begin
            entry_wr.free_line = req_ff.site_line;
            entry_wr.free_seen = 1'b1;
            entry_wr.freed     = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.out_sel)
         OUT_EVENT: begin
            rsp_in = event_rsp;
         end
         OUT_LEAK_MID, OUT_LEAK_LAST: begin
            rsp_in.status         = STATUS_LEAK;
            rsp_in.report_address = pend_ff.address;
            rsp_in.report_bytes   = pend_ff.bytes;
            rsp_in.report_line    = pend_ff.alloc_line;
            rsp_in.last           = (cmd.out_sel == OUT_LEAK_LAST);
         end
         OUT_SCAN_OK: begin
            rsp_in.status = STATUS_OK;
            rsp_in.last   = 1'b1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   assign stat.func     = req_ff.func;
   assign stat.hit      = (rd_data_ff.address == req_ff.block_address);
   assign stat.live     = !rd_data_ff.freed;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/hac_ctrl.sv]
module hac_ctrl #(
   parameter int TABLE_DEPTH = 32,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hac_pkg::stat_type stat,
   output hac_pkg::cmd_type  cmd,
   output logic [IDX_W-1:0]  mem_idx
);
   import hac_pkg::*;

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_SEARCH   = 2'd1;
   localparam logic [1:0] S_FINISH   = 2'd2;
   localparam logic [1:0] S_SCAN_END = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic              full_ff, full_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [LEAK_W-1:0] leak_n_ff, leak_n_in;

   logic lookup;
   logic scan;
   logic leak_seen;
   logic stall;
   logic hit_now;
   logic rd_go;
   logic exhausted;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      full_ff    <= full_in;
      leak_n_ff  <= leak_n_in;
   end

   always_comb begin
      lookup    = (stat.func == FUNC_ALLOC) || (stat.func == FUNC_FREE);
      scan      = (stat.func == FUNC_SCAN);
      leak_seen = scan && cmp_valid_ff && stat.live;
      stall     = leak_seen && pend_valid_ff && !stat.out_free;
      hit_now   = lookup && cmp_valid_ff && stat.hit;
      rd_go     = (rd_idx_ff < count_ff) && !stall && !hit_now;
      exhausted = (rd_idx_ff == count_ff) && !cmp_valid_ff;
   end

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      full_in       = full_ff;
      pend_valid_in = pend_valid_ff;
      leak_n_in     = leak_n_ff;
      cmd           = '0;
      cmd.found     = found_ff;
      cmd.full      = full_ff;
      mem_idx       = rd_idx_ff[IDX_W-1:0];
      req_ready     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load  = 1'b1;
               rd_idx_in     = '0;
               pend_valid_in = 1'b0;
               leak_n_in     = '0;
               state_in      = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (!lookup && !scan) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_en    = rd_go;
               cmp_valid_in = stall ? cmp_valid_ff : rd_go;
               if (rd_go) begin
                  rd_idx_in  = rd_idx_ff + CNT_W'(1);
                  cmp_idx_in = rd_idx_ff[IDX_W-1:0];
               end
               if (lookup) begin
                  if (hit_now) begin
                     found_in = 1'b1;
                     full_in  = 1'b0;
                     state_in = S_FINISH;
                  end else if (exhausted) begin
                     found_in = 1'b0;
                     full_in  = (count_ff == CNT_W'(TABLE_DEPTH));
                     state_in = S_FINISH;
                  end
               end else begin
                  if (leak_seen && !stall) begin
                     cmd.pend_load = 1'b1;
                     pend_valid_in = 1'b1;
                     leak_n_in     = leak_n_ff + LEAK_W'(1);
                     if (pend_valid_ff) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_LEAK_MID;
                     end
                     if (leak_n_ff + LEAK_W'(1) == LEAK_W'(MAX_RESULTS)) begin
                        state_in = S_SCAN_END;
                     end
                  end else if (exhausted) begin
                     state_in = S_SCAN_END;
                  end
               end
            end
         end
         S_FINISH: begin
            mem_idx = found_ff ? cmp_idx_ff : count_ff[IDX_W-1:0];
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_EVENT;
               cmd.wr_en    = !full_ff;
               if (!found_ff && !full_ff) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN_END: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_sel   = pend_valid_ff ? OUT_LEAK_LAST : OUT_SCAN_OK;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[test/tb_heap_allocation_checker_unit.sv]
`timescale 1ns / 100ps

module tb_heap_allocation_checker_unit;
   import hac_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int POOL_SIZE = 20;
   localparam int RANDOM_EVENTS = 100;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int error_count = 0;
   int idle_pct = 0;
   bit quiet = 1'b0;
   bit long_hold = 1'b0;

   rsp_type pending_reports[$];

   logic [47:0] slot_address[TABLE_DEPTH];
   logic [31:0] slot_bytes[TABLE_DEPTH];
   logic [31:0] slot_alloc_line[TABLE_DEPTH];
   logic [31:0] slot_free_line[TABLE_DEPTH];
   bit          slot_freed[TABLE_DEPTH];
   bit          slot_free_seen[TABLE_DEPTH];
   int          slot_count = 0;

   logic [47:0] addr_pool[POOL_SIZE];

   heap_allocation_checker_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [47:0] fresh_address();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic rsp_type make_report(logic [2:0] status, logic [47:0] addr,
                                           logic [31:0] bytes, logic [31:0] line,
                                           logic last);
      rsp_type r;
      r.status = status;
      r.report_address = addr;
      r.report_bytes = bytes;
      r.report_line = line;
      r.last = last;
      return r;
   endfunction

   function automatic int find_slot(logic [47:0] addr);
      for (int i = 0; i < slot_count; i++) begin
         if (slot_address[i] == addr) begin
            return i;
         end
      end
      if (slot_count >= TABLE_DEPTH) begin
         return -1;
      end
      slot_address[slot_count] = addr;
      slot_bytes[slot_count] = '0;
      slot_alloc_line[slot_count] = '0;
      slot_free_line[slot_count] = '0;
      slot_freed[slot_count] = 1'b1;
      slot_free_seen[slot_count] = 1'b0;
      slot_count++;
      return slot_count - 1;
   endfunction

   function automatic void predict_heap_event(req_type item);
      int idx;
      int live_total;
      int leaks;
      live_total = 0;
      leaks = 0;
      case (item.func)
         FUNC_ALLOC: begin
            idx = find_slot(item.block_address);
            if (idx < 0) begin
               pending_reports.push_back(make_report(STATUS_FULL, item.block_address,
                                                     '0, '0, 1'b1));
            end else if (!slot_freed[idx]) begin
               pending_reports.push_back(make_report(STATUS_REALLOC, item.block_address,
                                                     slot_bytes[idx],
                                                     slot_alloc_line[idx], 1'b1));
            end else begin
               slot_bytes[idx] = item.block_bytes;
               slot_alloc_line[idx] = item.site_line;
               slot_freed[idx] = 1'b0;
               pending_reports.push_back(make_report(STATUS_OK, item.block_address,
                                                     '0, '0, 1'b1));
            end
         end
         FUNC_FREE: begin
            idx = find_slot(item.block_address);
            if (idx < 0) begin
               pending_reports.push_back(make_report(STATUS_FULL, item.block_address,
                                                     '0, '0, 1'b1));
            end else if (slot_freed[idx] && slot_free_seen[idx]) begin
               pending_reports.push_back(make_report(STATUS_DOUBLE, item.block_address,
                                                     '0, slot_free_line[idx], 1'b1));
            end else if (slot_freed[idx]) begin
               pending_reports.push_back(make_report(STATUS_BAD, item.block_address,
                                                     '0, '0, 1'b1));
            end else begin
               slot_free_line[idx] = item.site_line;
               slot_free_seen[idx] = 1'b1;
               slot_freed[idx] = 1'b1;
               pending_reports.push_back(make_report(STATUS_OK, item.block_address,
                                                     '0, '0, 1'b1));
            end
         end
         FUNC_SCAN: begin
            for (int i = 0; i < slot_count; i++) begin
               if (!slot_freed[i] && live_total < MAX_RESULTS) begin
                  live_total++;
               end
            end
            if (live_total == 0) begin
               pending_reports.push_back(make_report(STATUS_OK, '0, '0, '0, 1'b1));
            end
            for (int i = 0; i < slot_count; i++) begin
               if (!slot_freed[i] && leaks < live_total) begin
                  leaks++;
                  pending_reports.push_back(make_report(STATUS_LEAK, slot_address[i],
                                                        slot_bytes[i],
                                                        slot_alloc_line[i],
                                                        leaks == live_total));
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %h",
                        $time, rsp_payload);
               error_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("status", 48'(want.status), 48'(rsp_payload.status));
               check_field("report_address", want.report_address,
                           rsp_payload.report_address);
               check_field("report_bytes", 48'(want.report_bytes),
                           48'(rsp_payload.report_bytes));
               check_field("report_line", 48'(want.report_line),
                           48'(rsp_payload.report_line));
               check_field("last", 48'(want.last), 48'(rsp_payload.last));
            end
         end
         if (req_valid && req_ready) begin
            predict_heap_event(req_payload);
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(99) < idle_pct / 4) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(logic [1:0] func, logic [47:0] addr,
                               logic [31:0] bytes, logic [31:0] line);
      req_type item;
      item.func = func;
      item.block_address = addr;
      item.block_bytes = bytes;
      item.site_line = line;
      @(negedge clock);
      if (!quiet && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic test_empty_scan();
      send_request(FUNC_SCAN, fresh_address(), $urandom, $urandom);
   endtask

   task automatic test_unused_func();
      send_request(FUNC_UNUSED, fresh_address(), $urandom, $urandom);
      send_request(FUNC_UNUSED, '1, '1, '1);
   endtask

   task automatic test_alloc_free_pairs();
      send_request(FUNC_ALLOC, '0, '0, '0);
      send_request(FUNC_ALLOC, '0, '1, '1);
      send_request(FUNC_FREE, '0, '0, '1);
      send_request(FUNC_FREE, '0, '0, 32'd5);
      send_request(FUNC_ALLOC, '0, 32'h8000_0000, 32'h0000_0001);
      send_request(FUNC_ALLOC, '1, '1, '1);
      send_request(FUNC_ALLOC, '1, '0, '0);
   endtask

   task automatic test_bad_free();
      logic [47:0] addr;
      addr = fresh_address();
      send_request(FUNC_FREE, addr, '1, 32'd17);
      send_request(FUNC_FREE, addr, '0, 32'd18);
      send_request(FUNC_ALLOC, addr, 32'd64, 32'd19);
      send_request(FUNC_FREE, addr, '0, 32'd20);
      send_request(FUNC_FREE, addr, '0, 32'd21);
   endtask

   task automatic test_leak_scan();
      send_request(FUNC_SCAN, '1, '1, '1);
      send_request(FUNC_FREE, '1, '0, 32'hdead_beef);
      send_request(FUNC_SCAN, '0, '0, '0);
   endtask

   task automatic test_random_traffic();
      int sent;
      int pick;
      logic [1:0] func;
      logic [47:0] addr;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         addr_pool[i] = fresh_address();
      end
      sent = 0;
      while (sent < RANDOM_EVENTS) begin
         if (sent % 25 == 0) begin
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            func = FUNC_UNUSED;
         end else if (pick < 50) begin
            func = FUNC_ALLOC;
         end else if (pick < 92) begin
            func = FUNC_FREE;
         end else begin
            func = FUNC_SCAN;
         end
         if ($urandom_range(99) < 5) begin
            addr = fresh_address();
         end else begin
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
         end
         send_request(func, addr, $urandom, $urandom);
         if (func != FUNC_UNUSED) begin
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      long_hold = 1'b1;
      repeat (6) begin
         send_request($urandom_range(1) ? FUNC_ALLOC : FUNC_FREE,
                      addr_pool[$urandom_range(POOL_SIZE - 1)], $urandom, $urandom);
      end
      wait (!long_hold);
   endtask

   task automatic test_table_full();
      quiet = 1'b1;
      repeat (TABLE_DEPTH) begin
         send_request(FUNC_ALLOC, fresh_address(), $urandom, $urandom);
      end
      send_request(FUNC_ALLOC, fresh_address(), $urandom, $urandom);
      send_request(FUNC_FREE, fresh_address(), $urandom, $urandom);
      send_request(FUNC_SCAN, '0, '0, '0);
      send_request(FUNC_FREE, addr_pool[0], '0, 32'd99);
      send_request(FUNC_ALLOC, addr_pool[1], 32'd7, 32'd100);
      send_request(FUNC_SCAN, '1, '1, '1);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_scan();
      test_unused_func();
      test_alloc_free_pairs();
      test_bad_free();
      test_leak_scan();
      test_random_traffic();
      test_backpressure();
      test_table_full();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("heap_allocation_checker_unit regression: pass");
      end else begin
         $display("heap_allocation_checker_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("heap_allocation_checker_unit regression: fail");
      $finish;
   end

endmodule
